@@ hdl/dcs_pkg.sv @@
// ----------------------------------------------------------------------------
// dcs_pkg
// Types, command word constants and helpers shared by the command sequencer.
// ----------------------------------------------------------------------------
package dcs_pkg;

  // Command codes on the mode field
  typedef enum logic [1:0] {
    MODE_WAVE  = 2'd0,
    MODE_SLEEP = 2'd1,
    MODE_WAKE  = 2'd2,
    MODE_AMP   = 2'd3
  } mode_t;

  // Position within the six-word set-waveform run
  typedef enum logic [2:0] {
    STEP_RESET   = 3'd0,
    STEP_B28     = 3'd1,
    STEP_LSB     = 3'd2,
    STEP_MSB     = 3'd3,
    STEP_PHASE   = 3'd4,
    STEP_CONTROL = 3'd5
  } step_t;

  // Waveform codes
  localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
  localparam logic [1:0] WAVE_SQUARE   = 2'd2;

  // Chip selects
  localparam logic TARGET_DDS = 1'b0;
  localparam logic TARGET_POT = 1'b1;

  // Command words and tags
  localparam logic [15:0] WORD_RESET   = 16'h0100;
  localparam logic [15:0] WORD_B28     = 16'h2100;
  localparam logic [15:0] TAG_FREQ0    = 16'h4000;
  localparam logic [15:0] TAG_FREQ1    = 16'h8000;
  localparam logic [15:0] TAG_PHASE    = 16'hC000;
  localparam logic [15:0] CTRL_SINE    = 16'h2000;
  localparam logic [15:0] CTRL_TRI     = 16'h2002;
  localparam logic [15:0] CTRL_SQUARE  = 16'h2028;
  localparam logic [15:0] WORD_SLEEP   = 16'h2C00;
  localparam logic [15:0] WORD_POT     = 16'h1100;

  // Tuning word: freq * 2^28 / 25 MHz = freq * 2^22 / 390625
  localparam int unsigned FREQ_W      = 24;
  localparam int unsigned TUNE_W      = 28;
  localparam int unsigned HALF_W      = 14;
  localparam int unsigned TUNE_SHIFT  = 22;
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned DIV_W       = 19;
  localparam int unsigned RECIP_W     = 32;
  localparam int unsigned NUM_W       = FREQ_W + TUNE_SHIFT;
  localparam int unsigned PROD_W      = FREQ_W + RECIP_W;
  localparam int unsigned BACK_W      = TUNE_W + DIV_W;
  localparam logic [DIV_W-1:0] MCLK_DIV = 19'd390625;
  // floor(2^50 / 390625), truncation error below one step for 24-bit input
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << (TUNE_SHIFT + RECIP_SHIFT)) / 64'd390625);

  // Classified command carried from front to back
  typedef struct packed {
    mode_t              mode;
    logic               freq_reg;
    logic [TUNE_W-1:0]  tune;
    logic [1:0]         wave;
    logic [11:0]        phase;
    logic [7:0]         amp;
  } cmd_t;

  // Waveform control word
  function automatic logic [15:0] ctrl_word(input logic [1:0] wave);
    logic [15:0] w;
    if (wave == WAVE_TRIANGLE) begin
      w = CTRL_TRI;
    end else if (wave == WAVE_SQUARE) begin
      w = CTRL_SQUARE;
    end else begin
      w = CTRL_SINE;
    end
    return w;
  endfunction

endpackage

@@ hdl/dds_command_sequencer.sv @@
// ----------------------------------------------------------------------------
// dds_command_sequencer
// Turns one command request into the run of 16-bit words for a DDS chip and
// a digital potentiometer.
// ----------------------------------------------------------------------------
// A set-waveform request yields a run of six words; sleep, wake and
// amplitude requests yield one word each, so the sustained rate is one
// output word per cycle while out_stall is low, paced by the back-end word
// sequencer. A request passes a three-stage tuning-word pipeline (reciprocal
// multiply, back-multiply, remainder correction), a QUEUE_DEPTH-entry command
// queue and the output register before its first word appears. Requests keep
// being accepted while earlier runs are still being emitted, until the
// queue and pipeline fill. The last flag marks the final word of each run.
// ----------------------------------------------------------------------------
module dds_command_sequencer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   mode,
  input  logic [23:0]  freq_hz,
  input  logic         freq_reg,
  input  logic [1:0]   wave,
  input  logic [11:0]  phase,
  input  logic [7:0]   amp,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [15:0]  word,
  output logic         target,
  output logic         last
);

  logic           cmd_valid;
  logic           cmd_ready;
  dcs_pkg::cmd_t  cmd;
  dcs_pkg::cmd_t  head_cmd;
  logic           head_valid;
  logic           pop;

  // request intake and tuning word
  dcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .freq_hz   (freq_hz),
    .freq_reg  (freq_reg),
    .wave      (wave),
    .phase     (phase),
    .amp       (amp),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  // decoupling queue
  dcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_valid),
    .push_cmd   (cmd),
    .push_ready (cmd_ready),
    .pop        (pop),
    .head_cmd   (head_cmd),
    .head_valid (head_valid)
  );

  // word sequencer
  dcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_cmd   (head_cmd),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word       (word),
    .target     (target),
    .last       (last)
  );

endmodule

@@ hdl/dcs_front.sv @@
// ----------------------------------------------------------------------------
// dcs_front
// Accepts requests and computes the frequency tuning word in three stages:
// reciprocal multiply, back-multiply, remainder correction.
// ----------------------------------------------------------------------------
module dcs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          mode,
  input  logic [23:0]         freq_hz,
  input  logic                freq_reg,
  input  logic [1:0]          wave,
  input  logic [11:0]         phase,
  input  logic [7:0]          amp,
  output logic                cmd_valid,
  output dcs_pkg::cmd_t       cmd,
  input  logic                cmd_ready
);

  // stage registers
  logic                          s1_valid;
  dcs_pkg::cmd_t                 s1_cmd;
  logic [dcs_pkg::FREQ_W-1:0]    s1_freq;
  logic [dcs_pkg::PROD_W-1:0]    s1_prod;

  logic                          s2_valid;
  dcs_pkg::cmd_t                 s2_cmd;
  logic [dcs_pkg::FREQ_W-1:0]    s2_freq;
  logic [dcs_pkg::TUNE_W-1:0]    s2_q0;
  logic [dcs_pkg::BACK_W-1:0]    s2_qd;

  logic                          s3_valid;
  dcs_pkg::cmd_t                 s3_cmd;

  logic s1_ready, s2_ready, s3_ready;
  dcs_pkg::cmd_t                 in_cmd;
  dcs_pkg::cmd_t                 s3_load;
  logic [dcs_pkg::TUNE_W-1:0]    q0;
  logic [dcs_pkg::NUM_W-1:0]     num;
  logic [dcs_pkg::NUM_W-1:0]     rem;
  logic [dcs_pkg::TUNE_W-1:0]    tune;

  // stage advance
  assign s3_ready = !s3_valid || cmd_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;

  // classify the incoming request
  always_comb begin
    in_cmd          = '0;
    in_cmd.mode     = dcs_pkg::mode_t'(mode);
    in_cmd.freq_reg = freq_reg;
    in_cmd.wave     = wave;
    in_cmd.phase    = phase;
    in_cmd.amp      = amp;
  end

  // quotient estimate and exact remainder
  assign q0   = s1_prod[dcs_pkg::PROD_W-1 -: dcs_pkg::TUNE_W];
  assign num  = {s2_freq, {dcs_pkg::TUNE_SHIFT{1'b0}}};
  assign rem  = num - s2_qd[dcs_pkg::NUM_W-1:0];
  assign tune = (rem >= dcs_pkg::NUM_W'(dcs_pkg::MCLK_DIV)) ? s2_q0 + 1'b1 : s2_q0;

  // command with its finished tuning word
  always_comb begin
    s3_load      = s2_cmd;
    s3_load.tune = tune;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_cmd  <= in_cmd;
      s1_freq <= freq_hz;
      s1_prod <= dcs_pkg::PROD_W'(freq_hz) * dcs_pkg::PROD_W'(dcs_pkg::RECIP);
    end
    if (s2_ready && s1_valid) begin
      s2_cmd  <= s1_cmd;
      s2_freq <= s1_freq;
      s2_q0   <= q0;
      s2_qd   <= dcs_pkg::BACK_W'(q0) * dcs_pkg::BACK_W'(dcs_pkg::MCLK_DIV);
    end
    if (s3_ready && s2_valid) begin
      s3_cmd <= s3_load;
    end
  end

  assign cmd_valid = s3_valid;
  assign cmd       = s3_cmd;

endmodule

@@ hdl/dcs_queue.sv @@
// ----------------------------------------------------------------------------
// dcs_queue
// Small register FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
module dcs_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dcs_pkg::cmd_t  push_cmd,
  output logic           push_ready,
  input  logic           pop,
  output dcs_pkg::cmd_t  head_cmd,
  output logic           head_valid
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dcs_pkg::cmd_t  store [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = store[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr] <= push_cmd;
  end

endmodule

@@ hdl/dcs_back.sv @@
// ----------------------------------------------------------------------------
// dcs_back
// Walks the command at the queue head and, unless stalled, emits one word per
// cycle into the output register; keeps the saved waveform control word.
// ----------------------------------------------------------------------------
module dcs_back (
  input  logic           clk,
  input  logic           rst,
  input  dcs_pkg::cmd_t  head_cmd,
  input  logic           head_valid,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [15:0]    word,
  output logic           target,
  output logic           last
);

  dcs_pkg::step_t step;
  dcs_pkg::step_t step_next;
  logic [15:0]    saved_control;
  logic           out_load;
  logic [15:0]    sel_word;
  logic           sel_target;
  logic           sel_last;
  logic [15:0]    tag;
  logic [15:0]    ctrl;

  assign out_load = !out_valid || !out_stall;
  assign pop      = out_load && head_valid && sel_last;
  assign tag      = head_cmd.freq_reg ? dcs_pkg::TAG_FREQ1 : dcs_pkg::TAG_FREQ0;
  assign ctrl     = dcs_pkg::ctrl_word(head_cmd.wave);

  // word selection for the current step
  always_comb begin
    sel_word   = dcs_pkg::WORD_SLEEP;
    sel_target = dcs_pkg::TARGET_DDS;
    sel_last   = 1'b1;
    unique case (head_cmd.mode)
      dcs_pkg::MODE_WAVE: begin
        sel_last = (step == dcs_pkg::STEP_CONTROL);
        unique case (step)
          dcs_pkg::STEP_RESET: sel_word = dcs_pkg::WORD_RESET;
          dcs_pkg::STEP_B28:   sel_word = dcs_pkg::WORD_B28;
          dcs_pkg::STEP_LSB:
            sel_word = tag | 16'(head_cmd.tune[dcs_pkg::HALF_W-1:0]);
          dcs_pkg::STEP_MSB:
            sel_word = tag | 16'(head_cmd.tune[dcs_pkg::TUNE_W-1:dcs_pkg::HALF_W]);
          dcs_pkg::STEP_PHASE: sel_word = dcs_pkg::TAG_PHASE | 16'(head_cmd.phase);
          default:             sel_word = ctrl;
        endcase
      end
      dcs_pkg::MODE_SLEEP: sel_word = dcs_pkg::WORD_SLEEP;
      dcs_pkg::MODE_WAKE:  sel_word = saved_control;
      dcs_pkg::MODE_AMP: begin
        sel_word   = dcs_pkg::WORD_POT | 16'(head_cmd.amp);
        sel_target = dcs_pkg::TARGET_POT;
      end
    endcase
  end

  // next step of the run
  always_comb begin
    unique case (step)
      dcs_pkg::STEP_RESET: step_next = dcs_pkg::STEP_B28;
      dcs_pkg::STEP_B28:   step_next = dcs_pkg::STEP_LSB;
      dcs_pkg::STEP_LSB:   step_next = dcs_pkg::STEP_MSB;
      dcs_pkg::STEP_MSB:   step_next = dcs_pkg::STEP_PHASE;
      dcs_pkg::STEP_PHASE: step_next = dcs_pkg::STEP_CONTROL;
      default:             step_next = dcs_pkg::STEP_RESET;
    endcase
  end

  // sequencer control and saved control word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      step          <= dcs_pkg::STEP_RESET;
      saved_control <= dcs_pkg::CTRL_SINE;
    end else if (out_load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        step <= sel_last ? dcs_pkg::STEP_RESET : step_next;
        if (sel_last && head_cmd.mode == dcs_pkg::MODE_WAVE) saved_control <= ctrl;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load && head_valid) begin
      word   <= sel_word;
      target <= sel_target;
      last   <= sel_last;
    end
  end

endmodule
